// ===== rtl/iira_pkg.sv =====
`timescale 1ns / 1ps

package iira_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 64;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_FIELDS_W  = ACT_W + POS_W + WORD_W;
  localparam int OUT_FIELDS_W = STAT_W + WORD_W + CNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_REVERSE = 3'd4,
    ACT_CLEAR   = 3'd5,
    ACT_READ    = 3'd6
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_INS_SHIFT,
    S_REM_SHIFT,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUSH,
    WR_INS,
    WR_REV_LO,
    WR_REV_HI
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_LO,
    RD_HI
  } rd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef struct packed {
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    cnt_op_e cnt_op;
    logic    shift_init_ins;
    logic    shift_init_rem;
    logic    shift_step;
    logic    rev_init;
    logic    rev_step;
    logic    tmp_load;
    logic    res_load;
    stat_e   res_status;
    logic    res_use_rdata;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic cnt_lt2;
    logic shift_done;
    logic rev_done;
    logic can_load;
  } dp_sts_t;

endpackage

// ===== rtl/indexed_insert_remove_array.sv =====
`timescale 1ns / 1ps
// Push, pop, clear, rejected actions and short reverses give their word in the cycle after
// acceptance; a read first waits in the read-wait state for the memory word.
// Insert and remove move one entry per cycle through the memory, which has one read and one
// write port; insert then writes the new word. Reverse swaps each pair: read low, read high,
// write low, write high. A new word is accepted only when idle and the output register has room.
// Reset clears the element count and the control state; the element memory is not cleared.

module indexed_insert_remove_array (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: action (3), position (7), item_word (64), zero fill.
  input  logic [iira_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: status (2), read_word (64), fill_count (7), zero fill.
  output logic [iira_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [iira_pkg::ACT_W-1:0]  in_action;
  logic [iira_pkg::POS_W-1:0]  in_pos;
  logic [iira_pkg::WORD_W-1:0] in_word;
  logic [iira_pkg::STAT_W-1:0] out_status;
  logic [iira_pkg::WORD_W-1:0] out_word;
  logic [iira_pkg::CNT_W-1:0]  out_fill;
  iira_pkg::ctrl_cmd_t         cmd;
  iira_pkg::dp_sts_t           sts;

  assign in_action = s_axis_tdata[iira_pkg::ACT_W-1:0];
  assign in_pos    = s_axis_tdata[iira_pkg::ACT_W +: iira_pkg::POS_W];
  assign in_word   = s_axis_tdata[iira_pkg::ACT_W + iira_pkg::POS_W +: iira_pkg::WORD_W];

  iira_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_action_i(in_action),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iira_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_pos_i    (in_pos),
    .in_word_i   (in_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_status_o(out_status),
    .out_word_o  (out_word),
    .out_fill_o  (out_fill)
  );

  assign m_axis_tdata = iira_pkg::OUT_TDATA_W'({out_fill, out_word, out_status});

endmodule

// ===== rtl/iira_ram.sv =====
`timescale 1ns / 1ps

module iira_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/iira_datapath.sv =====
`timescale 1ns / 1ps

module iira_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [iira_pkg::POS_W-1:0]  in_pos_i,
  input  logic [iira_pkg::WORD_W-1:0] in_word_i,
  input  iira_pkg::ctrl_cmd_t         cmd_i,
  output iira_pkg::dp_sts_t           sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [iira_pkg::STAT_W-1:0] out_status_o,
  output logic [iira_pkg::WORD_W-1:0] out_word_o,
  output logic [iira_pkg::CNT_W-1:0]  out_fill_o
);

  logic [iira_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [iira_pkg::CNT_W-1:0]  mv_q;
  logic [iira_pkg::ADDR_W-1:0] src_q, dst_q;
  logic                        pend_q;
  logic                        dir_ins_q;
  logic [iira_pkg::ADDR_W-1:0] lo_q, hi_q;
  logic [iira_pkg::ADDR_W-1:0] pos_q;
  logic [iira_pkg::WORD_W-1:0] word_q;
  logic [iira_pkg::WORD_W-1:0] tmp_q;

  logic                        out_valid_q;
  logic [iira_pkg::STAT_W-1:0] out_status_q;
  logic [iira_pkg::WORD_W-1:0] out_word_q;
  logic [iira_pkg::CNT_W-1:0]  out_fill_q;

  logic [iira_pkg::CMP_W-1:0]  pos_x, cnt_x;
  logic [iira_pkg::CNT_W-1:0]  cnt_m1;
  logic [iira_pkg::POS_W-1:0]  pos_p1;
  logic                        can_load;

  logic                        ram_we, ram_re;
  logic [iira_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [iira_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  assign pos_x    = iira_pkg::CMP_W'(in_pos_i);
  assign cnt_x    = iira_pkg::CMP_W'(cnt_q);
  assign cnt_m1   = cnt_q - iira_pkg::CNT_W'(1);
  assign pos_p1   = in_pos_i + iira_pkg::POS_W'(1);
  assign can_load = !out_valid_q || out_ready_i;

  assign sts_o.full       = (cnt_q == iira_pkg::CNT_W'(iira_pkg::DEPTH));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.pos_gt_cnt = (pos_x > cnt_x);
  assign sts_o.pos_ge_cnt = (pos_x >= cnt_x);
  assign sts_o.cnt_lt2    = (cnt_q < iira_pkg::CNT_W'(2));
  assign sts_o.shift_done = (mv_q == '0) && !pend_q;
  assign sts_o.rev_done   = !(lo_q < hi_q);
  assign sts_o.can_load   = can_load;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (cmd_i.wr_sel)
      iira_pkg::WR_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[iira_pkg::ADDR_W-1:0];
        ram_wdata = in_word_i;
      end
      iira_pkg::WR_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = word_q;
      end
      iira_pkg::WR_REV_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ram_rdata;
      end
      iira_pkg::WR_REV_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
      end
      default: begin
        if (cmd_i.shift_step && pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end
      end
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (cmd_i.rd_sel)
      iira_pkg::RD_POS: begin
        ram_re    = 1'b1;
        ram_raddr = in_pos_i[iira_pkg::ADDR_W-1:0];
      end
      iira_pkg::RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = lo_q;
      end
      iira_pkg::RD_HI: begin
        ram_re    = 1'b1;
        ram_raddr = hi_q;
      end
      default: begin
        if (cmd_i.shift_step && (mv_q != '0)) begin
          ram_re    = 1'b1;
          ram_raddr = src_q;
        end
      end
    endcase
  end

  iira_ram #(
    .WIDTH(iira_pkg::WORD_W),
    .DEPTH(iira_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    case (cmd_i.cnt_op)
      iira_pkg::CNT_INC: cnt_d = cnt_q + iira_pkg::CNT_W'(1);
      iira_pkg::CNT_DEC: cnt_d = cnt_m1;
      iira_pkg::CNT_CLR: cnt_d = '0;
      default:           cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mv_q        <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      pend_q      <= 1'b0;
      dir_ins_q   <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.shift_init_ins) begin
        mv_q      <= iira_pkg::CNT_W'(cnt_x - pos_x);
        src_q     <= cnt_m1[iira_pkg::ADDR_W-1:0];
        dir_ins_q <= 1'b1;
        pend_q    <= 1'b0;
      end else if (cmd_i.shift_init_rem) begin
        mv_q      <= iira_pkg::CNT_W'(cnt_x - pos_x - iira_pkg::CMP_W'(1));
        src_q     <= pos_p1[iira_pkg::ADDR_W-1:0];
        dir_ins_q <= 1'b0;
        pend_q    <= 1'b0;
      end else if (cmd_i.shift_step) begin
        if (mv_q != '0) begin
          mv_q   <= mv_q - iira_pkg::CNT_W'(1);
          pend_q <= 1'b1;
          if (dir_ins_q) begin
            dst_q <= src_q + iira_pkg::ADDR_W'(1);
            src_q <= src_q - iira_pkg::ADDR_W'(1);
          end else begin
            dst_q <= src_q - iira_pkg::ADDR_W'(1);
            src_q <= src_q + iira_pkg::ADDR_W'(1);
          end
        end else begin
          pend_q <= 1'b0;
        end
      end
      if (cmd_i.rev_init) begin
        lo_q <= '0;
        hi_q <= cnt_m1[iira_pkg::ADDR_W-1:0];
      end else if (cmd_i.rev_step) begin
        lo_q <= lo_q + iira_pkg::ADDR_W'(1);
        hi_q <= hi_q - iira_pkg::ADDR_W'(1);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_init_ins) begin
      pos_q  <= in_pos_i[iira_pkg::ADDR_W-1:0];
      word_q <= in_word_i;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= ram_rdata;
    end
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_word_q   <= cmd_i.res_use_rdata ? ram_rdata : '0;
      out_fill_q   <= cnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_word_o   = out_word_q;
  assign out_fill_o   = out_fill_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= iira_pkg::CNT_W'(iira_pkg::DEPTH))
    else $error("element count exceeds depth");

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> can_load)
    else $error("result overwritten before it was taken");

  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(cmd_i.shift_step))
    else $error("shift write pending without a shift read");

  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(cmd_i.res_load))
    else $error("count changed without a result");

  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_sel != iira_pkg::WR_NONE) |-> !(cmd_i.shift_step && pend_q))
    else $error("two writes to the element memory in one cycle");

endmodule

// ===== rtl/iira_ctrl.sv =====
`timescale 1ns / 1ps

module iira_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [iira_pkg::ACT_W-1:0] in_action_i,
  input  iira_pkg::dp_sts_t          sts_i,
  output iira_pkg::ctrl_cmd_t        cmd_o
);

  iira_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iira_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{
      wr_sel:         iira_pkg::WR_NONE,
      rd_sel:         iira_pkg::RD_NONE,
      cnt_op:         iira_pkg::CNT_HOLD,
      res_status:     iira_pkg::STAT_OK,
      default:        1'b0
    };
    unique case (state_q)
      iira_pkg::S_IDLE: begin
        in_ready_o = sts_i.can_load;
        if (in_valid_i && sts_i.can_load) begin
          unique case (iira_pkg::act_e'(in_action_i))
            iira_pkg::ACT_PUSH: begin
              cmd_o.res_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = iira_pkg::STAT_FULL;
              end else begin
                cmd_o.wr_sel = iira_pkg::WR_PUSH;
                cmd_o.cnt_op = iira_pkg::CNT_INC;
              end
            end
            iira_pkg::ACT_POP: begin
              cmd_o.res_load = 1'b1;
              if (sts_i.empty) begin
                cmd_o.res_status = iira_pkg::STAT_EMPTY;
              end else begin
                cmd_o.cnt_op = iira_pkg::CNT_DEC;
              end
            end
            iira_pkg::ACT_INSERT: begin
              if (sts_i.pos_gt_cnt) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = iira_pkg::STAT_RANGE;
              end else if (sts_i.full) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = iira_pkg::STAT_FULL;
              end else begin
                cmd_o.shift_init_ins = 1'b1;
                state_d              = iira_pkg::S_INS_SHIFT;
              end
            end
            iira_pkg::ACT_REMOVE: begin
              if (sts_i.pos_ge_cnt) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = iira_pkg::STAT_RANGE;
              end else begin
                cmd_o.shift_init_rem = 1'b1;
                state_d              = iira_pkg::S_REM_SHIFT;
              end
            end
            iira_pkg::ACT_REVERSE: begin
              if (sts_i.cnt_lt2) begin
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.rev_init = 1'b1;
                state_d        = iira_pkg::S_REV_RD_LO;
              end
            end
            iira_pkg::ACT_CLEAR: begin
              cmd_o.res_load = 1'b1;
              cmd_o.cnt_op   = iira_pkg::CNT_CLR;
            end
            iira_pkg::ACT_READ: begin
              if (sts_i.pos_ge_cnt) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = iira_pkg::STAT_RANGE;
              end else begin
                cmd_o.rd_sel = iira_pkg::RD_POS;
                state_d      = iira_pkg::S_RD_WAIT;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      iira_pkg::S_RD_WAIT: begin
        if (sts_i.can_load) begin
          cmd_o.res_load      = 1'b1;
          cmd_o.res_use_rdata = 1'b1;
          state_d             = iira_pkg::S_IDLE;
        end
      end
      iira_pkg::S_INS_SHIFT: begin
        if (!sts_i.shift_done) begin
          cmd_o.shift_step = 1'b1;
        end else if (sts_i.can_load) begin
          cmd_o.wr_sel   = iira_pkg::WR_INS;
          cmd_o.cnt_op   = iira_pkg::CNT_INC;
          cmd_o.res_load = 1'b1;
          state_d        = iira_pkg::S_IDLE;
        end
      end
      iira_pkg::S_REM_SHIFT: begin
        if (!sts_i.shift_done) begin
          cmd_o.shift_step = 1'b1;
        end else if (sts_i.can_load) begin
          cmd_o.cnt_op   = iira_pkg::CNT_DEC;
          cmd_o.res_load = 1'b1;
          state_d        = iira_pkg::S_IDLE;
        end
      end
      iira_pkg::S_REV_RD_LO: begin
        if (!sts_i.rev_done) begin
          cmd_o.rd_sel = iira_pkg::RD_LO;
          state_d      = iira_pkg::S_REV_RD_HI;
        end else if (sts_i.can_load) begin
          cmd_o.res_load = 1'b1;
          state_d        = iira_pkg::S_IDLE;
        end
      end
      iira_pkg::S_REV_RD_HI: begin
        cmd_o.rd_sel   = iira_pkg::RD_HI;
        cmd_o.tmp_load = 1'b1;
        state_d        = iira_pkg::S_REV_WR_LO;
      end
      iira_pkg::S_REV_WR_LO: begin
        cmd_o.wr_sel = iira_pkg::WR_REV_LO;
        state_d      = iira_pkg::S_REV_WR_HI;
      end
      iira_pkg::S_REV_WR_HI: begin
        cmd_o.wr_sel   = iira_pkg::WR_REV_HI;
        cmd_o.rev_step = 1'b1;
        state_d        = iira_pkg::S_REV_RD_LO;
      end
      default: begin
        state_d = iira_pkg::S_IDLE;
      end
    endcase
  end

endmodule
